// ----- src/thadc_pkg.sv -----
// Shared types, constants and helpers of the thermistor temperature converter.
package thadc_pkg;

    // default ADC resolution and input width
    localparam int ADC_BITS_DEF = 24;
    localparam int X_W          = 24;

    // log2 datapath: integer part, Q30 mantissa, Q28 fraction
    localparam int K_W       = 5;
    localparam int M_W       = 31;
    localparam int FRAC_W    = 28;
    localparam int LOG_STEPS = FRAC_W;
    localparam int LOG_LANES = 4;
    localparam int LV_W      = K_W + FRAC_W;
    localparam int L2_W      = LV_W + 2;

    // lane assignment of the four logarithms
    localparam int LANE_RS = 0;
    localparam int LANE_R0 = 1;
    localparam int LANE_A  = 2;
    localparam int LANE_B  = 3;

    // divider geometry
    localparam int RES_W   = 20;
    localparam int BETA_W  = 14;
    localparam int T0_W    = 12;
    localparam int PROD_W  = 62;
    localparam int INV0_NW = 53;
    localparam int DVS_W   = 56;
    localparam int QK_W    = 60;
    localparam int TERM_W  = 56;
    localparam int INVT_W  = 57;
    localparam int TEMP_W  = 16;

    // fixed-point constants
    localparam logic [FRAC_W-1:0] LN2_Q28          = 28'd186065279;
    localparam logic [QK_W:0]     KELVIN_OFFSET_Q8 = 61'd699264;
    localparam logic [INV0_NW-1:0] INV0_NUM        = 53'd20 << 48;
    localparam logic [QK_W-1:0]   KELVIN_NUM       = 60'd10 << 56;

    // configuration reset values
    localparam logic [RES_W-1:0]  SERIES_RST  = 20'd10000;
    localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd10000;
    localparam logic [BETA_W-1:0] BETA_RST    = 14'd3950;
    localparam logic [T0_W-1:0]   T0_RST      = 12'd250;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SERIES   = 3'd0,
        CFG_NOMINAL  = 3'd1,
        CFG_BETA     = 3'd2,
        CFG_T0       = 3'd3,
        CFG_LOW_SIDE = 3'd4
    } t_cfg_idx;

    // one logarithm in progress
    typedef struct packed {
        logic [K_W-1:0]    k;
        logic [M_W-1:0]    m;
        logic [FRAC_W-1:0] frac;
    } t_log_lane;

    // normalize a nonzero operand to a Q30 mantissa in [1,2)
    function automatic t_log_lane log_norm(input logic [X_W-1:0] x);
        t_log_lane l;
        logic [K_W-1:0] k;
        k = '0;
        for (int i = 1; i < X_W; i++) begin
            if (x[i]) k = K_W'(i);
        end
        l.k    = k;
        l.m    = M_W'(x) << (K_W'(M_W - 1) - k);
        l.frac = '0;
        return l;
    endfunction

endpackage

// ----- src/thadc_log_cell.sv -----
// One squaring step of the log2 chain for all four lanes.
module thadc_log_cell
    import thadc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  t_log_lane [LOG_LANES-1:0]    i_lane,
    output t_log_lane [LOG_LANES-1:0]    o_lane
);

    t_log_lane [LOG_LANES-1:0] r_lane;
    t_log_lane [LOG_LANES-1:0] n_lane;
    logic [2*M_W-1:0]          w_sq [LOG_LANES];
    logic [M_W:0]              w_s  [LOG_LANES];

    // square the mantissa, renormalize and shift in one fraction bit
    always_comb begin
        for (int j = 0; j < LOG_LANES; j++) begin
            w_sq[j] = (2*M_W)'(i_lane[j].m) * (2*M_W)'(i_lane[j].m);
            w_s[j]  = w_sq[j][2*M_W-1:M_W-1];
            n_lane[j].k    = i_lane[j].k;
            n_lane[j].m    = w_s[j][M_W] ? w_s[j][M_W:1] : w_s[j][M_W-1:0];
            n_lane[j].frac = {i_lane[j].frac[FRAC_W-2:0], w_s[j][M_W]};
        end
    end

    // hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- src/thadc_div_cell.sv -----
// One quotient bit of a restoring divider; remainder and quotient share one word.
module thadc_div_cell
    import thadc_pkg::*;
#(
    parameter int DW = BETA_W,
    parameter int NW = PROD_W
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DW+NW-1:0]   i_acc,
    input  logic [DW-1:0]      i_dvs,
    output logic [DW+NW-1:0]   o_acc,
    output logic [DW-1:0]      o_dvs
);

    logic [DW+NW-1:0] r_acc;
    logic [DW-1:0]    r_dvs;
    logic [DW:0]      w_top;
    logic [DW:0]      w_diff;
    logic             w_ge;
    logic [DW+NW-1:0] n_acc;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_top  = i_acc[DW+NW-1:NW-1];
        w_diff = w_top - {1'b0, i_dvs};
        w_ge   = (w_top >= {1'b0, i_dvs});
        n_acc  = {(w_ge ? w_diff[DW-1:0] : w_top[DW-1:0]), i_acc[NW-2:0], w_ge};
    end

    // advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
            r_dvs <= i_dvs;
        end
    end

    assign o_acc = r_acc;
    assign o_dvs = r_dvs;

endmodule

// ----- src/thermistor_adc_to_temperature_core.sv -----
// NTC thermistor converter: ADC code to temperature in tenths of a degree Celsius.
//
// The core takes one ADC code per clock while ready is high and returns one temperature
// per code, in order, through 160 pipeline stages plus the output register.
// Most of the stages are cells in the datapath: 28 squaring cells that build
// the four base-2 logarithms one fraction bit each, a 62-cell restoring divider by Beta
// and a 60-cell restoring divider that forms the kelvin value, each cell yielding one
// quotient bit. A stalled output parks one result in a skid register; ready drops only
// once that register is full. Configuration is to be written only while no request is in
// flight; the core does not enforce this. The 1/T0 term comes from its own 53-cell divider
// fed from the registers, settled long before a request taken after the write reaches it.
module thermistor_adc_to_temperature_core
    import thadc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [X_W-1:0]            i_adc_code,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [TEMP_W-1:0]  o_temp_tenths,
    output logic                      o_out_of_range,
    input  logic                      i_cfg_wr_en,
    input  logic [2:0]                i_cfg_index,
    input  logic [RES_W-1:0]          i_cfg_wdata
);

    localparam logic [X_W:0] FS    = (X_W+1)'(1) << ADC_BITS;
    localparam int           DEPTH = 2 + LOG_STEPS + 3 + PROD_W + 2 + QK_W + 3;
    localparam int           BW    = BETA_W + PROD_W;
    localparam int           IW    = BETA_W + INV0_NW;
    localparam int           KW    = DVS_W + QK_W;

    // configuration registers
    logic [RES_W-1:0]  r_series;
    logic [RES_W-1:0]  r_nominal;
    logic [BETA_W-1:0] r_beta;
    logic [T0_W-1:0]   r_t0;
    logic              r_low_side;

    // flow control
    logic              w_en;
    logic [DEPTH-1:0]  r_vld;
    logic              r_out_vld;
    logic              r_skid_vld;
    logic              w_take;

    // front end
    logic [X_W:0]      w_n_ext;
    logic [X_W:0]      w_n;
    logic [X_W:0]      w_rest;
    logic [X_W-1:0]    r_s0_a;
    logic [X_W-1:0]    r_s0_b;
    logic [X_W-1:0]    w_rs_eff;
    logic [X_W-1:0]    w_r0_eff;
    logic [BETA_W-1:0] w_beta_eff;
    t_log_lane [LOG_LANES-1:0] r_s1_lane;
    t_log_lane [LOG_LANES-1:0] w_log [0:LOG_STEPS];

    // log combine and scaling
    logic [LV_W-1:0]        w_lv [LOG_LANES];
    logic signed [L2_W-1:0] r_c1_l2;
    logic [L2_W-2:0]        r_c2_mag;
    logic                   r_c2_neg;
    logic [PROD_W-1:0]      r_c3_prod;
    logic                   r_c3_neg;
    logic [PROD_W-1:0]      r_neg_line;

    // dividers
    logic [BW-1:0]     w_bacc [0:PROD_W];
    logic [BETA_W-1:0] w_bdvs [0:PROD_W];
    logic [IW-1:0]     w_iacc [0:INV0_NW];
    logic [BETA_W-1:0] w_idvs [0:INV0_NW];
    logic [KW-1:0]     w_kacc [0:QK_W];
    logic [DVS_W-1:0]  w_kdvs [0:QK_W];
    logic signed [BETA_W:0] w_d_s;
    logic [INV0_NW-1:0]     w_inv0_num;

    // term, inverse temperature, back end
    logic [PROD_W:0]          w_tq;
    logic signed [TERM_W-1:0] r_c4_term;
    logic [INVT_W-1:0]        w_invt;
    logic                     w_nonpos;
    logic [DVS_W-1:0]         r_c5_dvs;
    logic                     r_c5_nonpos;
    logic [QK_W-1:0]          r_nonpos_line;
    logic [QK_W:0]            r_f1_tc;
    logic                     r_f1_nonpos;
    logic [QK_W-1:0]          r_f2_mag;
    logic                     r_f2_neg;
    logic                     r_f2_nonpos;
    logic [QK_W:0]            w_rnd;
    logic [QK_W-8:0]          w_r;
    logic [TEMP_W-1:0]        n_f3_temp;
    logic                     n_f3_oor;
    logic [TEMP_W-1:0]        r_f3_temp;
    logic                     r_f3_oor;
    logic [TEMP_W-1:0]        r_out_temp;
    logic                     r_out_oor;
    logic [TEMP_W-1:0]        r_skid_temp;
    logic                     r_skid_oor;

    // write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series   <= SERIES_RST;
            r_nominal  <= NOMINAL_RST;
            r_beta     <= BETA_RST;
            r_t0       <= T0_RST;
            r_low_side <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SERIES:   r_series   <= i_cfg_wdata;
                CFG_NOMINAL:  r_nominal  <= i_cfg_wdata;
                CFG_BETA:     r_beta     <= i_cfg_wdata[BETA_W-1:0];
                CFG_T0:       r_t0       <= i_cfg_wdata[T0_W-1:0];
                CFG_LOW_SIDE: r_low_side <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // substitute one for zero resistor and Beta values
    assign w_rs_eff   = X_W'((r_series  == '0) ? RES_W'(1) : r_series);
    assign w_r0_eff   = X_W'((r_nominal == '0) ? RES_W'(1) : r_nominal);
    assign w_beta_eff = (r_beta == '0) ? BETA_W'(1) : r_beta;

    // the request pipe moves unless the skid register is occupied
    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;
    assign w_take  = r_out_vld && i_ready;

    // clamp the code and split the divider into its two legs
    always_comb begin
        w_n_ext = {1'b0, i_adc_code};
        if (w_n_ext == '0) begin
            w_n = (X_W+1)'(1);
        end else if (w_n_ext >= FS) begin
            w_n = FS - (X_W+1)'(1);
        end else begin
            w_n = w_n_ext;
        end
        w_rest = FS - w_n;
    end

    // front-end registers: divider legs, then normalized operands
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_a <= r_low_side ? w_n[X_W-1:0] : w_rest[X_W-1:0];
            r_s0_b <= r_low_side ? w_rest[X_W-1:0] : w_n[X_W-1:0];
            r_s1_lane[LANE_RS] <= log_norm(w_rs_eff);
            r_s1_lane[LANE_R0] <= log_norm(w_r0_eff);
            r_s1_lane[LANE_A]  <= log_norm(r_s0_a);
            r_s1_lane[LANE_B]  <= log_norm(r_s0_b);
        end
    end

    // squaring chain: one fraction bit per cell
    assign w_log[0] = r_s1_lane;
    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        thadc_log_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_log[g]),
            .o_lane (w_log[g+1])
        );
    end

    // combine logs, take magnitude, scale by ln 2
    always_comb begin
        for (int j = 0; j < LOG_LANES; j++) begin
            w_lv[j] = {w_log[LOG_STEPS][j].k, w_log[LOG_STEPS][j].frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_l2   <= signed'(L2_W'(w_lv[LANE_RS])) - signed'(L2_W'(w_lv[LANE_R0]))
                       + signed'(L2_W'(w_lv[LANE_A]))  - signed'(L2_W'(w_lv[LANE_B]));
            r_c2_neg  <= r_c1_l2[L2_W-1];
            r_c2_mag  <= r_c1_l2[L2_W-1] ? (L2_W-1)'(-r_c1_l2) : r_c1_l2[L2_W-2:0];
            r_c3_neg  <= r_c2_neg;
            r_c3_prod <= PROD_W'(r_c2_mag) * PROD_W'(LN2_Q28);
            r_neg_line <= {r_neg_line[PROD_W-2:0], r_c3_neg};
        end
    end

    // divide by Beta, one quotient bit per cell
    assign w_bacc[0] = {BETA_W'(0), r_c3_prod};
    assign w_bdvs[0] = w_beta_eff;
    for (genvar g = 0; g < PROD_W; g++) begin : g_bdiv
        thadc_div_cell #(
            .DW (BETA_W),
            .NW (PROD_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_acc (w_bacc[g]),
            .i_dvs (w_bdvs[g]),
            .o_acc (w_bacc[g+1]),
            .o_dvs (w_bdvs[g+1])
        );
    end

    // 1/T0 = 20 / (2*T0 + 5463), rounded, from the live registers
    assign w_d_s      = {{2{r_t0[T0_W-1]}}, r_t0, 1'b0} + (BETA_W+1)'(5463);
    assign w_inv0_num = INV0_NUM + INV0_NW'(w_d_s[BETA_W-1:1]);
    assign w_iacc[0]  = {BETA_W'(0), w_inv0_num};
    assign w_idvs[0]  = w_d_s[BETA_W-1:0];
    for (genvar g = 0; g < INV0_NW; g++) begin : g_idiv
        thadc_div_cell #(
            .DW (BETA_W),
            .NW (INV0_NW)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_acc (w_iacc[g]),
            .i_dvs (w_idvs[g]),
            .o_acc (w_iacc[g+1]),
            .o_dvs (w_idvs[g+1])
        );
    end

    // round the term to Q48, add 1/T0, pick the kelvin divisor
    assign w_tq     = (PROD_W+1)'(w_bacc[PROD_W][PROD_W-1:0]) + (PROD_W+1)'(128);
    assign w_invt   = {r_c4_term[TERM_W-1], r_c4_term}
                    + INVT_W'(w_iacc[INV0_NW][INV0_NW-1:0]);
    assign w_nonpos = w_invt[INVT_W-1] || (w_invt == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c4_term   <= r_neg_line[PROD_W-1] ? -signed'(TERM_W'(w_tq[PROD_W:8]))
                                                :  signed'(TERM_W'(w_tq[PROD_W:8]));
            r_c5_nonpos <= w_nonpos;
            r_c5_dvs    <= w_nonpos ? DVS_W'(1) : w_invt[DVS_W-1:0];
            r_nonpos_line <= {r_nonpos_line[QK_W-2:0], r_c5_nonpos};
        end
    end

    // kelvin tenths in Q8 = 10 * 2^56 / invT
    assign w_kacc[0] = {DVS_W'(0), KELVIN_NUM};
    assign w_kdvs[0] = r_c5_dvs;
    for (genvar g = 0; g < QK_W; g++) begin : g_kdiv
        thadc_div_cell #(
            .DW (DVS_W),
            .NW (QK_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_acc (w_kacc[g]),
            .i_dvs (w_kdvs[g]),
            .o_acc (w_kacc[g+1]),
            .o_dvs (w_kdvs[g+1])
        );
    end

    // round half away from zero and saturate to 16 bits
    assign w_rnd = (QK_W+1)'(r_f2_mag) + (QK_W+1)'(128);
    assign w_r   = w_rnd[QK_W:8];

    always_comb begin
        n_f3_oor  = 1'b0;
        n_f3_temp = TEMP_W'(w_r);
        priority if (r_f2_nonpos) begin
            n_f3_temp = 16'h7FFF;
            n_f3_oor  = 1'b1;
        end else if (!r_f2_neg && (w_r > (QK_W-7)'(32767))) begin
            n_f3_temp = 16'h7FFF;
            n_f3_oor  = 1'b1;
        end else if (r_f2_neg && (w_r > (QK_W-7)'(32768))) begin
            n_f3_temp = 16'h8000;
            n_f3_oor  = 1'b1;
        end else if (r_f2_neg) begin
            n_f3_temp = -TEMP_W'(w_r);
        end else begin
            n_f3_temp = TEMP_W'(w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_tc     <= {1'b0, w_kacc[QK_W][QK_W-1:0]} - KELVIN_OFFSET_Q8;
            r_f1_nonpos <= r_nonpos_line[QK_W-1];
            r_f2_neg    <= r_f1_tc[QK_W];
            r_f2_mag    <= r_f1_tc[QK_W] ? QK_W'(-r_f1_tc) : r_f1_tc[QK_W-1:0];
            r_f2_nonpos <= r_f1_nonpos;
            r_f3_temp   <= n_f3_temp;
            r_f3_oor    <= n_f3_oor;
        end
    end

    // advance the valid line and steer results into output or skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
            if (r_vld[DEPTH-1]) begin
                if (!r_out_vld || w_take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (w_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_temp <= r_skid_temp;
                r_out_oor  <= r_skid_oor;
            end
        end else if (r_vld[DEPTH-1]) begin
            if (!r_out_vld || w_take) begin
                r_out_temp <= r_f3_temp;
                r_out_oor  <= r_f3_oor;
            end else begin
                r_skid_temp <= r_f3_temp;
                r_skid_oor  <= r_f3_oor;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_temp_tenths  = signed'(r_out_temp);
    assign o_out_of_range = r_out_oor;

    // an occupied skid register always sits behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a request with no result in front");

    // the skid register fills only when the result in front was not taken
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_ready))
        else $error("skid register filled while the output was free");

    // a result leaves only when taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_out_vld) && $past(i_rst_n)) |-> $past(i_ready))
        else $error("result dropped without being taken");

    // the range flag comes only with a saturated value
    a_flag_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_oor) |-> (r_out_temp == 16'h7FFF || r_out_temp == 16'h8000))
        else $error("out of range flag on an unsaturated result");

endmodule
